// ----- src/avsync_pkg.sv -----
// ----------------------------------------------------------------------------
// avsync_pkg
// Shared types and constants for the audio/video sync sample count adjuster.
// ----------------------------------------------------------------------------
package avsync_pkg;

  // default parameter values
  localparam int unsigned MAX_FRAME_SAMPLES_DEF  = 16384;
  localparam int unsigned CORRECTION_PERCENT_DEF = 10;

  // field widths
  localparam int FRAME_W  = 14;
  localparam int TIME_W   = 32;
  localparam int WANTED_W = 15;
  localparam int COEF_W   = 16;
  localparam int THR_W    = 31;
  localparam int RATE_W   = 18;
  localparam int OFS_W    = 19;
  localparam int ACC_W    = 40;
  localparam int DIFF_W   = 34;

  // shared shift-add multiplier operand widths
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_AVG_COEF       = 2'd0;
  localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SAMPLE_RATE    = 2'd2;
  localparam logic [1:0] REG_AV_OFFSET      = 2'd3;

  // register reset values
  localparam logic [COEF_W-1:0] AVG_COEF_RST       = 16'd52057;
  localparam logic [THR_W-1:0]  DIFF_THRESHOLD_RST = 31'd65536;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST    = 18'd48000;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIFF,
    S_CHECK,
    S_MUL1,
    S_RND1,
    S_ACC,
    S_START2,
    S_MUL2,
    S_RND2,
    S_THR,
    S_MUL3,
    S_WANT,
    S_CLAMP,
    S_DONE
  } avsync_state_t;

  // multiplier status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

// ----- src/av_sync_sample_count_adjust.sv -----
// ----------------------------------------------------------------------------
// av_sync_sample_count_adjust
// Audio/video sync sample count compensation for one decoded audio frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one transaction per decoded audio frame: sample count, audio
//   clock, video clock (signed Q16.16 s) and the playing flag. out_* returns
//   one transaction per input: the wanted sample count plus the corrected and
//   out-of-window flags. cfg_* is an APB-style register port (pready tied
//   high) holding the averaging weight, threshold, sample rate and offset;
//   write it only while the block is idle.
//   The time from input acceptance to output valid depends on the path: not
//   playing or out of window, average below threshold, or count corrected. It
//   is set by up to three passes through the shared 18-step shift-add
//   multiplier; the divide by 100 for the clamp bounds runs alongside the
//   first pass. One frame is processed at a time, so a new frame is taken
//   only once the previous one is through; in_tready is high whenever the
//   sequencer is idle, also while a finished result waits on out_tready.
//   A stalled receiver holds the result and the next frame waits before its
//   result is stored. Synchronous reset clears the accumulator, restores the
//   register defaults and empties the output stage.
// ----------------------------------------------------------------------------
module av_sync_sample_count_adjust
  import avsync_pkg::*;
#(
  parameter int unsigned MAX_FRAME_SAMPLES  = MAX_FRAME_SAMPLES_DEF,
  parameter int unsigned CORRECTION_PERCENT = CORRECTION_PERCENT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input frame channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] frame_samples, [45:14] audio_time, [77:46] video_time,
  // [78] playing, [79] zero
  input  logic [79:0] in_tdata,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [14:0] wanted_samples, [15] corrected, [16] out_of_window, [23:17] zero
  output logic [23:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW     = $clog2(MAX_FRAME_SAMPLES);
  localparam int KLO    = 100 - CORRECTION_PERCENT;
  localparam int KHI    = 100 + CORRECTION_PERCENT;
  localparam int XW     = NW + 8;
  localparam int DCW    = $clog2(XW + 1);
  localparam int DivBy  = 100;

  localparam logic [16:0] NMAX = 17'(MAX_FRAME_SAMPLES - 1);
  localparam logic signed [OFS_W-1:0]  OFS_HI = 19'sd131072;
  localparam logic signed [OFS_W-1:0]  OFS_LO = -19'sd131072;
  localparam logic signed [DIFF_W-1:0] NOSYNC_HI = 34'sd655360;
  localparam logic signed [DIFF_W-1:0] NOSYNC_LO = -34'sd655360;
  localparam logic signed [41:0] ACC_MAX42 = 42'sd549755813887;
  localparam logic signed [41:0] ACC_MIN42 = -42'sd549755813888;

  // configuration registers
  logic [COEF_W-1:0]        coef_r;
  logic [THR_W-1:0]         thr_r;
  logic [RATE_W-1:0]        rate_r;
  logic signed [OFS_W-1:0]  ofs_r;
  logic                     cfg_we;
  logic signed [OFS_W-1:0]  ofs_in;

  // sequencer and datapath
  avsync_state_t             state_r, state_nxt;
  logic [NW-1:0]             n_r;
  logic signed [TIME_W-1:0]  audio_r;
  logic signed [TIME_W-1:0]  video_r;
  logic                      play_r;
  logic signed [TIME_W:0]    vo_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [DIFF_W-1:0]  diff_neg;
  logic [19:0]               absdiff_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]          acc_mag;
  logic [40:0]               rnd_r;
  logic signed [41:0]        acc_sum;
  logic signed [24:0]        want_r;
  logic signed [24:0]        lo_s;
  logic signed [24:0]        hi_s;
  logic signed [24:0]        want_c;
  logic [21:0]               trunc_mag;
  logic                      oow;
  logic                      thr_hit;
  logic [16:0]               in_n17;
  logic [16:0]               n17;

  // results
  logic [WANTED_W-1:0] res_w_r;
  logic                res_c_r;
  logic                res_o_r;
  logic [WANTED_W-1:0] out_w_r;
  logic                out_c_r;
  logic                out_o_r;
  logic                out_tvalid_r;
  logic                out_load;

  // multiplier
  logic               mul_start;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  mul_sts_t           mul_sts;
  logic [MUL_PW-1:0]  mul_prod;
  logic [MUL_PW-1:0]  mul_rnd;

  // clamp bound dividers
  logic           dv_start;
  logic           dv_run_r;
  logic [DCW-1:0] dv_cnt_r;
  logic [XW-1:0]  dlo_r;
  logic [XW-1:0]  dhi_r;
  logic [6:0]     rlo_r;
  logic [6:0]     rhi_r;
  logic [7:0]     lo_trial;
  logic [7:0]     hi_trial;
  logic           lo_ge;
  logic           hi_ge;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign ofs_in     = signed'(cfg_pwdata[OFS_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= AVG_COEF_RST;
      thr_r  <= DIFF_THRESHOLD_RST;
      rate_r <= SAMPLE_RATE_RST;
      ofs_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        REG_AVG_COEF:       coef_r <= cfg_pwdata[COEF_W-1:0];
        REG_DIFF_THRESHOLD: thr_r  <= cfg_pwdata[THR_W-1:0];
        REG_SAMPLE_RATE:    rate_r <= cfg_pwdata[RATE_W-1:0];
        REG_AV_OFFSET: begin
          if (ofs_in > OFS_HI) begin
            ofs_r <= OFS_HI;
          end else if (ofs_in < OFS_LO) begin
            ofs_r <= OFS_LO;
          end else begin
            ofs_r <= ofs_in;
          end
        end
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_AVG_COEF:       cfg_prdata = 32'(coef_r);
      REG_DIFF_THRESHOLD: cfg_prdata = 32'(thr_r);
      REG_SAMPLE_RATE:    cfg_prdata = 32'(rate_r);
      REG_AV_OFFSET:      cfg_prdata = {{(32 - OFS_W){ofs_r[OFS_W-1]}}, ofs_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // operand select: weight pass, average pass, sample rate pass
  always_comb begin
    case (state_r)
      S_CHECK: begin
        mul_a = acc_mag;
        mul_b = MUL_BW'(coef_r);
      end
      S_START2: begin
        mul_a = acc_mag;
        mul_b = MUL_BW'(18'h10000 - MUL_BW'(coef_r));
      end
      default: begin
        mul_a = MUL_AW'(absdiff_r);
        mul_b = rate_r;
      end
    endcase
  end

  avsync_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign mul_rnd = mul_prod + MUL_PW'(32768);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_n17 = 17'(in_tdata[FRAME_W-1:0]);
  assign n17    = (in_n17 > NMAX) ? NMAX : in_n17;
  assign oow    = (diff_r >= NOSYNC_HI) || (diff_r <= NOSYNC_LO);
  assign thr_hit = rnd_r >= 41'(thr_r);
  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    dv_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SUM;
      end
      S_SUM: begin
        dv_start  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (!play_r || oow) begin
          state_nxt = S_DONE;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_sts.done) state_nxt = S_RND1;
      end
      S_RND1:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_START2;
      S_START2: begin
        mul_start = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (mul_sts.done) state_nxt = S_RND2;
      end
      S_RND2:  state_nxt = S_THR;
      S_THR: begin
        if (thr_hit) begin
          mul_start = 1'b1;
          state_nxt = S_MUL3;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL3: begin
        if (mul_sts.done) state_nxt = S_WANT;
      end
      S_WANT:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // accumulator update, saturated to the accumulator range
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      acc_sum = 42'(diff_r) - signed'(42'(rnd_r));
    end else begin
      acc_sum = 42'(diff_r) + signed'(42'(rnd_r));
    end
  end

  // corrected count and clamp bounds
  assign diff_neg  = -diff_r;
  assign trunc_mag = mul_prod[37:16];
  assign lo_s      = signed'(25'(dlo_r));
  assign hi_s      = signed'(25'(dhi_r));

  always_comb begin
    if (want_r < lo_s) begin
      want_c = lo_s;
    end else if (want_r > hi_s) begin
      want_c = hi_s;
    end else begin
      want_c = want_r;
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (state_r == S_ACC) begin
      if (acc_sum > ACC_MAX42) begin
        acc_r <= ACC_MAX42[ACC_W-1:0];
      end else if (acc_sum < ACC_MIN42) begin
        acc_r <= ACC_MIN42[ACC_W-1:0];
      end else begin
        acc_r <= acc_sum[ACC_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_r     <= n17[NW-1:0];
          audio_r <= signed'(in_tdata[45:14]);
          video_r <= signed'(in_tdata[77:46]);
          play_r  <= in_tdata[78];
        end
      end
      S_SUM:  vo_r   <= 33'(video_r) + 33'(ofs_r);
      S_DIFF: diff_r <= 34'(audio_r) - 34'(vo_r);
      S_CHECK: begin
        absdiff_r <= diff_r[DIFF_W-1] ? diff_neg[19:0] : diff_r[19:0];
        res_w_r   <= WANTED_W'(n_r);
        res_c_r   <= 1'b0;
        res_o_r   <= play_r & oow;
      end
      S_RND1: rnd_r <= mul_rnd[56:16];
      S_RND2: rnd_r <= mul_rnd[56:16];
      S_THR: begin
        res_w_r <= WANTED_W'(n_r);
        res_c_r <= 1'b0;
        res_o_r <= 1'b0;
      end
      S_WANT: begin
        if (diff_r[DIFF_W-1]) begin
          want_r <= 25'(n_r) - 25'(trunc_mag);
        end else begin
          want_r <= 25'(n_r) + 25'(trunc_mag);
        end
      end
      S_CLAMP: begin
        res_w_r <= want_c[WANTED_W-1:0];
        res_c_r <= 1'b1;
        res_o_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // clamp bounds: count * (100 -/+ percent) / 100, restoring division one
  // quotient bit per cycle, quotient shifts in behind the dividend
  // ---------------------------------------------------------------------------
  always_comb begin
    lo_trial = {rlo_r, dlo_r[XW-1]};
    hi_trial = {rhi_r, dhi_r[XW-1]};
    lo_ge    = lo_trial >= 8'(DivBy);
    hi_ge    = hi_trial >= 8'(DivBy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_run_r <= 1'b0;
      dv_cnt_r <= '0;
    end else if (dv_start) begin
      dv_run_r <= 1'b1;
      dv_cnt_r <= '0;
    end else if (dv_run_r) begin
      dv_cnt_r <= dv_cnt_r + DCW'(1);
      if (dv_cnt_r == DCW'(XW - 1)) dv_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dlo_r <= XW'(n_r) * XW'(KLO);
      dhi_r <= XW'(n_r) * XW'(KHI);
      rlo_r <= '0;
      rhi_r <= '0;
    end else if (dv_run_r) begin
      dlo_r <= {dlo_r[XW-2:0], lo_ge};
      dhi_r <= {dhi_r[XW-2:0], hi_ge};
      rlo_r <= lo_ge ? 7'(lo_trial - 8'(DivBy)) : lo_trial[6:0];
      rhi_r <= hi_ge ? 7'(hi_trial - 8'(DivBy)) : hi_trial[6:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_w_r <= res_w_r;
      out_c_r <= res_c_r;
      out_o_r <= res_o_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_o_r, out_c_r, out_w_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_div_done_at_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |-> !dv_run_r)
    else $error("clamp bounds used before division finished");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier restarted while busy");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SUM))
    else $error("accepted transaction did not start processing");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result presented outside of the done state");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_c_r && out_o_r))
    else $error("corrected and out-of-window both set");
`endif

endmodule

// ----- src/avsync_mul.sv -----
// ----------------------------------------------------------------------------
// avsync_mul
// Unsigned serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module avsync_mul
  import avsync_pkg::*;
#(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output mul_sts_t         sts,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] a_r;
  logic [AW-1:0] hi_r;
  logic [BW-1:0] lo_r;
  logic [AW:0]   sum;
  logic [AW+BW:0] step;

  // add multiplicand when the current multiplier bit is set, then shift right
  always_comb begin
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    step = {sum, lo_r};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      {hi_r, lo_r} <= step[AW+BW:1];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = {hi_r, lo_r};

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for av_sync_sample_count_adjust. Frames are fed through
// the input stream with random gaps while the result stream stalls at random.
// A bit-accurate model of the weighted sync average and the sample count
// correction predicts each result, and every result is compared field by
// field. The register file is reprogrammed between runs, extremes included.
// ----------------------------------------------------------------------------
module tb
  import avsync_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WINDOW_LIMIT = 655360;
  localparam longint OFFSET_LIMIT = 131072;
  localparam longint ACC_MAX      = 64'sd549755813887;
  localparam longint ACC_MIN      = -ACC_MAX - 1;
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_FRAMES = 203;
  localparam int     MAX_REPORTS  = 10;

  typedef struct {
    logic [FRAME_W-1:0]       samples;
    logic signed [TIME_W-1:0] audio;
    logic signed [TIME_W-1:0] video;
    logic                     playing;
  } frame_t;

  typedef struct {
    logic [WANTED_W-1:0] wanted;
    logic                corrected;
    logic                out_of_window;
  } result_t;

  // dut connections
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // [13:0] frame_samples, [45:14] audio_time, [77:46] video_time,
  // [78] playing, [79] zero
  logic [79:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // [14:0] wanted_samples, [15] corrected, [16] out_of_window, [23:17] zero
  logic [23:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // sync model state and register copies
  logic [COEF_W-1:0] coef_q   = AVG_COEF_RST;
  logic [THR_W-1:0]  thr_q    = DIFF_THRESHOLD_RST;
  logic [RATE_W-1:0] rate_q   = SAMPLE_RATE_RST;
  longint            offset_q = 0;
  longint            acc_q    = 0;

  frame_t  pending_frames[$];
  result_t expected_results[$];
  frame_t  frame_on_bus;
  int      in_gap         = 0;
  int      out_stall      = 0;
  bit      in_idle_en     = 1'b1;
  bit      out_idle_en    = 1'b1;
  int      mismatch_count = 0;

  av_sync_sample_count_adjust u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial forever #5 clk = ~clk;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // q16 scaling, rounding half away from zero
  function automatic longint q16_round(longint p);
    longint m;
    m = (mag(p) + 32768) >>> 16;
    return (p < 0) ? -m : m;
  endfunction

  // q16 scaling, truncating toward zero
  function automatic longint q16_trunc(longint p);
    longint m;
    m = mag(p) >>> 16;
    return (p < 0) ? -m : m;
  endfunction

  // one frame through the sync model, updates the running average
  function automatic result_t advance_sync_model(frame_t f);
    result_t r;
    longint  count;
    longint  diff;
    longint  acc;
    longint  avg;
    longint  lo;
    longint  hi;
    longint  adj;
    longint  pct;
    count = longint'(f.samples);
    if (count > longint'(MAX_FRAME_SAMPLES_DEF) - 1)
      count = longint'(MAX_FRAME_SAMPLES_DEF) - 1;
    pct = longint'(CORRECTION_PERCENT_DEF);
    adj = count;
    r.corrected = 1'b0;
    r.out_of_window = 1'b0;
    if (f.playing) begin
      diff = longint'(f.audio) - (longint'(f.video) + offset_q);
      if (mag(diff) >= WINDOW_LIMIT) begin
        r.out_of_window = 1'b1;
      end else begin
        acc = diff + q16_round(longint'(coef_q) * acc_q);
        if (acc > ACC_MAX) acc = ACC_MAX;
        if (acc < ACC_MIN) acc = ACC_MIN;
        acc_q = acc;
        avg = q16_round(acc * (65536 - longint'(coef_q)));
        if (mag(avg) >= longint'(thr_q)) begin
          lo = count * (100 - pct) / 100;
          hi = count * (100 + pct) / 100;
          adj = count + q16_trunc(diff * longint'(rate_q));
          if (adj < lo) adj = lo;
          if (adj > hi) adj = hi;
          r.corrected = 1'b1;
        end
      end
    end
    r.wanted = adj[WANTED_W-1:0];
    return r;
  endfunction

  // setup and access cycle, the register is written at the last edge
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    longint ofs;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_AVG_COEF:       coef_q = value[COEF_W-1:0];
      REG_DIFF_THRESHOLD: thr_q  = value[THR_W-1:0];
      REG_SAMPLE_RATE:    rate_q = value[RATE_W-1:0];
      REG_AV_OFFSET: begin
        ofs = longint'(signed'(value[OFS_W-1:0]));
        if (ofs > OFFSET_LIMIT) ofs = OFFSET_LIMIT;
        if (ofs < -OFFSET_LIMIT) ofs = -OFFSET_LIMIT;
        offset_q = ofs;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [COEF_W-1:0] coef, input logic [THR_W-1:0] thr,
                               input logic [RATE_W-1:0] rate, input logic [OFS_W-1:0] ofs);
    write_register(REG_AVG_COEF, {16'd0, coef});
    write_register(REG_DIFF_THRESHOLD, {1'b0, thr});
    write_register(REG_SAMPLE_RATE, {14'd0, rate});
    write_register(REG_AV_OFFSET, {{(32 - OFS_W){ofs[OFS_W-1]}}, ofs});
  endtask

  // block is idle once nothing is queued, on the bus or outstanding
  task automatic await_all_results();
    do @(negedge clk);
    while (pending_frames.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  function automatic void push_frame(input logic [FRAME_W-1:0] s, input logic [31:0] a,
                                     input logic [31:0] v, input logic p);
    frame_t f;
    f.samples = s;
    f.audio   = a;
    f.video   = v;
    f.playing = p;
    pending_frames.push_back(f);
  endfunction

  // drift of a run of frames, from tiny to near the window edge
  function automatic longint random_drift();
    longint scale;
    case ($urandom_range(0, 3))
      0:       scale = 600000;
      1:       scale = 90000;
      2:       scale = 4000;
      default: scale = 250;
    endcase
    return longint'($urandom_range(0, int'(2 * scale))) - scale;
  endfunction

  // mostly in-window frames around the run drift, the rest noise
  function automatic frame_t random_frame(longint drift, longint spread);
    frame_t      f;
    longint      d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) f.samples = FRAME_W'($urandom);
    else f.samples = FRAME_W'($urandom_range(256, 4096));
    f.video   = $urandom;
    f.playing = 1'b1;
    if (pick < 8) begin
      f.playing = 1'b0;
      f.audio   = $urandom;
      return f;
    end
    if (pick < 14) begin
      f.audio = $urandom;
      return f;
    end
    if (pick < 22) d = WINDOW_LIMIT + longint'($urandom_range(0, 1 << 24));
    else if (pick < 28) d = WINDOW_LIMIT - longint'($urandom_range(0, 1));
    else d = drift + longint'($urandom_range(0, int'(2 * spread))) - spread;
    if (pick < 28 && $urandom_range(0, 1) == 1) d = -d;
    f.audio = TIME_W'(longint'(f.video) + offset_q + d);
    return f;
  endfunction

  // input driver
  always @(posedge clk) begin
    frame_t f;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(advance_sync_model(frame_on_bus));
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          f = pending_frames.pop_front();
          frame_on_bus <= f;
          in_tdata     <= {1'b0, f.playing, f.video, f.audio, f.samples};
          in_tvalid    <= 1'b1;
          if (in_idle_en && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    result_t got_res;
    result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res.wanted        = out_tdata[WANTED_W-1:0];
        got_res.corrected     = out_tdata[WANTED_W];
        got_res.out_of_window = out_tdata[WANTED_W+1];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result wanted=%0d corrected=%0b out_of_window=%0b",
                     $realtime, got_res.wanted, got_res.corrected, got_res.out_of_window);
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res.wanted !== exp_res.wanted || got_res.corrected !== exp_res.corrected ||
              got_res.out_of_window !== exp_res.out_of_window) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch wanted exp %0d got %0d, corrected exp %0b got %0b, %s",
                       $realtime, exp_res.wanted, got_res.wanted, exp_res.corrected,
                       got_res.corrected,
                       $sformatf("out_of_window exp %0b got %0b",
                                 exp_res.out_of_window, got_res.out_of_window));
          end
        end
      end
      if (out_stall != 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_idle_en && $urandom_range(0, 7) == 0) out_stall <= $urandom_range(1, 16);
      end
    end
  end

  // stimulus sequence
  initial begin
    longint      drift;
    longint      spread;
    int unsigned run_left;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at reset settings
    push_frame(14'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    push_frame(14'd16383, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    push_frame(14'd2048, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    push_frame(14'd2048, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    push_frame(14'd1000, 32'd655360, 32'd0, 1'b1);
    push_frame(14'd1000, 32'd0, 32'd655360, 1'b1);
    push_frame(14'd1000, 32'h7FFFFFFF, 32'h7FFFFC17, 1'b1);
    push_frame(14'd16383, 32'd655359, 32'd0, 1'b1);
    push_frame(14'd0, 32'd655359, 32'd0, 1'b1);
    push_frame(14'd1, 32'h80000000, 32'h80000000, 1'b1);
    repeat (5) push_frame(14'd4000, 32'd0, 32'd655359, 1'b1);
    // not playing keeps the average untouched
    push_frame(14'd16383, 32'd0, 32'd655359, 1'b0);
    push_frame(14'd4000, 32'd0, 32'd655359, 1'b1);
    // tiny differences corrected without hitting the clamp
    push_frame(14'd3000, 32'd20, 32'd0, 1'b1);
    push_frame(14'd3000, 32'd0, 32'd20, 1'b1);
    push_frame(14'd3000, 32'd7, 32'd0, 1'b1);
    await_all_results();

    // random runs, each under its own register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_settings(16'd0, 31'd0, 18'd8000, 19'd131072);
        1: load_settings(16'hFFFF, 31'h7FFFFFFF, 18'd192000, 19'(-131072));
        2: load_settings(AVG_COEF_RST, DIFF_THRESHOLD_RST, SAMPLE_RATE_RST, 19'h3FFFF);
        3: load_settings(16'd1, 31'd1, 18'h3FFFF, 19'h40000);
        4: load_settings(COEF_W'($urandom), THR_W'($urandom_range(0, 300000)), 18'd0,
                         19'd131073);
        7: load_settings(AVG_COEF_RST, 31'd32768, SAMPLE_RATE_RST, 19'(-20000));
        default: load_settings(COEF_W'($urandom), THR_W'($urandom >> $urandom_range(6, 31)),
                               RATE_W'($urandom_range(8000, 192000)), OFS_W'($urandom));
      endcase
      in_idle_en  = (p != 2 && p != NUM_PHASES - 1);
      out_idle_en = (p != 5 && p != NUM_PHASES - 1);
      run_left = 0;
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        if (run_left == 0) begin
          drift    = random_drift();
          spread   = mag(drift) / 8 + 16;
          run_left = $urandom_range(5, 40);
        end
        run_left--;
        pending_frames.push_back(random_frame(drift, spread));
      end
      await_all_results();
    end

    // catch stray results after the last one
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
